>>> rtl/she_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// she_pkg
// Shared constants, types and helper functions of the spherical harmonic unit.
// ============================================================================
package she_pkg;

    localparam int LMAX         = 8;
    localparam int ANGLE_BITS   = 16;
    localparam int IDX_W        = $clog2(LMAX + 1);
    localparam int K_W          = $clog2(LMAX + 3);
    localparam int VAL_W        = 34;
    localparam int COEF_W       = 32;
    localparam int OUT_W        = 18;
    localparam int CORDIC_STEPS = 26;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [VAL_W-1:0] CORDIC_GAIN  = VAL_W'(652032874);
    localparam logic signed [VAL_W-1:0] INV_SQRT_4PI = VAL_W'(75724244);
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    // Request to the shared multiplier: a * b, rounded to Q.28 or Q.26 scale
    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic                    coef_scale;  // 1: drop 26 bits, 0: drop 28 bits
    } mul_req_t;

    // Arctangent of 2^-i in turns, Q0.32
    function automatic logic signed [31:0] turn_atan(input logic [STEP_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // floor(sqrt(num/den * 2^52)) by bit search; evaluated at elaboration only
    function automatic logic [COEF_W-1:0] coef_q26(input longint unsigned num,
                                                   input longint unsigned den);
        logic [127:0] lim;
        logic [127:0] t;
        logic [31:0]  r;
        logic [31:0]  c;
        lim = 128'(num) << 52;
        r   = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (32'd1 << b);
            t = 128'(c) * 128'(c) * 128'(den);
            if (t <= lim) begin
                r = c;
            end
        end
        return r;
    endfunction

    // Round a Q.28 value half up to Q.16 and clip to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        logic signed [OUT_W-1:0] o;
        r = (v + VAL_W'(2048)) >>> 12;
        if (r > VAL_W'(OUT_MAX)) begin
            o = OUT_MAX;
        end else if (r < $signed(VAL_W'(OUT_MIN))) begin
            o = OUT_MIN;
        end else begin
            o = r[OUT_W-1:0];
        end
        return o;
    endfunction

endpackage

>>> rtl/she_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// she_mul
// Shared signed multiplier with half-up rounding and a registered result.
// ============================================================================
module she_mul import she_pkg::*; (
    input  logic                    aclk,
    input  mul_req_t                req,
    output logic signed [VAL_W-1:0] res
);

    logic signed [2*VAL_W-1:0] prod;
    logic signed [2*VAL_W-1:0] rnd;
    logic signed [VAL_W-1:0]   res_reg;
    logic signed [VAL_W-1:0]   res_next;

    // Multiply, round and scale back
    always_comb begin
        prod = req.a * req.b;
        if (req.coef_scale) begin
            rnd      = prod + (2*VAL_W)'(33'sd1 <<< 25);
            res_next = VAL_W'(rnd >>> 26);
        end else begin
            rnd      = prod + (2*VAL_W)'(33'sd1 <<< 27);
            res_next = VAL_W'(rnd >>> 28);
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

>>> rtl/she_cordic.sv
`timescale 1ns / 1ps
// ============================================================================
// she_cordic
// Iterative rotation CORDIC: cosine and sine of a Q0.32 turn angle, Q.28 out.
// ============================================================================
module she_cordic import she_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [31:0]             angle,
    output logic                    done,
    output logic signed [VAL_W-1:0] cos_out,
    output logic signed [VAL_W-1:0] sin_out
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [1:0]              quad_reg;
    logic signed [VAL_W-1:0] x_reg;
    logic signed [VAL_W-1:0] y_reg;
    logic signed [31:0]      z_reg;
    logic signed [VAL_W-1:0] cos_reg;
    logic signed [VAL_W-1:0] sin_reg;
    logic signed [VAL_W-1:0] xs;
    logic signed [VAL_W-1:0] ys;
    logic signed [VAL_W-1:0] xr;
    logic signed [VAL_W-1:0] yr;

    always_comb begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        xr = (x_reg + VAL_W'(2)) >>> 2;
        yr = (y_reg + VAL_W'(2)) >>> 2;
    end

    // Control: run the micro-rotations, then resolve the quadrant
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(CORDIC_STEPS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: one micro-rotation per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            quad_reg <= angle[31:30];
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= {2'b00, angle[29:0]};
        end else if (busy_reg) begin
            if (step_reg == STEP_W'(CORDIC_STEPS)) begin
                case (quad_reg)
                    2'd0: begin
                        cos_reg <= xr;
                        sin_reg <= yr;
                    end
                    2'd1: begin
                        cos_reg <= -yr;
                        sin_reg <= xr;
                    end
                    2'd2: begin
                        cos_reg <= -xr;
                        sin_reg <= -yr;
                    end
                    default: begin
                        cos_reg <= yr;
                        sin_reg <= -xr;
                    end
                endcase
            end else if (!z_reg[31]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - turn_atan(step_reg);
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + turn_atan(step_reg);
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

>>> rtl/spherical_harmonic_eval_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// spherical_harmonic_eval_unit
// Complex spherical harmonic Y_lm(theta, phi), signed Q2.16 real and imaginary.
// ============================================================================
// One word in, one word out. The unit takes one word at a time and drops
// s_axis_tready until its result has been taken. For a word with |m| > l or
// l > LMAX, m_axis_tvalid rises at the accepting edge itself, with a zero
// result and tuser set. Otherwise the unit starts the CORDIC on theta, runs
// the order steps, the first degree step and any further degree steps,
// fixes the sign, starts the CORDIC on m*phi and forms the two output
// products. s_axis_tready returns the cycle after the result is taken. The
// one CORDIC unit is used for cos/sin of theta and then of m*phi, and the
// one multiplier serves every product of the recurrence and the output.
// ============================================================================
module spherical_harmonic_eval_unit import she_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // degree[3:0], order[8:4], polar_angle[24:9], azimuth_angle[40:25], zero pad
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // real_part[17:0], imag_part[35:18], zero pad
    output logic [39:0] m_axis_tdata,
    // order_out_of_range[0]
    output logic        m_axis_tuser
);

    typedef enum logic [4:0] {
        S_IDLE, S_TH_START, S_TH_WAIT, S_AS1, S_AS2, S_AS3, S_UP1, S_UP2, S_UP3,
        S_RC1, S_RC2, S_RC3, S_RC4, S_FLIP, S_PH_START, S_PH_WAIT,
        S_OUT1, S_OUT2, S_OUT3, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [3:0]              l_reg;
    logic [4:0]              m_reg;
    logic [4:0]              ma_reg;
    logic [K_W-1:0]          k_reg;
    logic [31:0]             theta_reg;
    logic [31:0]             ang_reg;
    logic signed [VAL_W-1:0] x_reg;
    logic signed [VAL_W-1:0] s_reg;
    logic signed [VAL_W-1:0] p0_reg;
    logic signed [VAL_W-1:0] p1_reg;
    logic signed [VAL_W-1:0] t1_reg;
    logic signed [OUT_W-1:0] re_reg;
    logic signed [OUT_W-1:0] im_reg;
    logic                    flag_reg;
    logic                    valid_reg;

    logic [3:0]              in_l;
    logic [4:0]              in_m;
    logic [4:0]              in_ma;
    logic [ANGLE_BITS-1:0]   in_th;
    logic [ANGLE_BITS-1:0]   in_ph;
    logic [ANGLE_BITS-1:0]   m_ext;
    logic [ANGLE_BITS-1:0]   ang_low;
    logic                    in_bad;
    logic                    s_accept;

    mul_req_t                mreq;
    logic signed [VAL_W-1:0] mres;
    logic                    cd_start;
    logic [31:0]             cd_angle;
    logic                    cd_done;
    logic signed [VAL_W-1:0] cd_cos;
    logic signed [VAL_W-1:0] cd_sin;

    logic [IDX_W-1:0]        k_idx;
    logic [IDX_W-1:0]        ma_idx;
    logic [COEF_W-1:0]       coef_a [0:LMAX][0:LMAX];
    logic [COEF_W-1:0]       coef_b [0:LMAX][0:LMAX];
    logic [COEF_W-1:0]       coef_c [0:LMAX];
    logic [COEF_W-1:0]       coef_d [0:LMAX];

    // Recurrence coefficient tables, fixed at elaboration
    for (genvar gk = 0; gk <= LMAX; gk++) begin : g_row
        if (gk >= 1) begin : g_c
            assign coef_c[gk] = coef_q26(64'(2*gk + 1), 64'(2*gk));
        end else begin : g_c0
            assign coef_c[gk] = '0;
        end
        assign coef_d[gk] = coef_q26(64'(2*gk + 3), 64'd1);
        for (genvar gm = 0; gm <= LMAX; gm++) begin : g_col
            if (gk >= gm + 2) begin : g_ab
                assign coef_a[gk][gm] = coef_q26(64'(4*gk*gk - 1), 64'(gk*gk - gm*gm));
                assign coef_b[gk][gm] = coef_q26(64'((gk-1)*(gk-1) - gm*gm),
                                                 64'(4*(gk-1)*(gk-1) - 1));
            end else begin : g_ab0
                assign coef_a[gk][gm] = '0;
                assign coef_b[gk][gm] = '0;
            end
        end
    end

    // Decode the incoming word
    always_comb begin
        in_l    = s_axis_tdata[3:0];
        in_m    = s_axis_tdata[8:4];
        in_th   = s_axis_tdata[9 +: ANGLE_BITS];
        in_ph   = s_axis_tdata[25 +: ANGLE_BITS];
        in_ma   = in_m[4] ? (~in_m + 5'd1) : in_m;
        in_bad  = (in_l > 4'(LMAX)) || (in_ma > {1'b0, in_l});
        m_ext   = {{(ANGLE_BITS-5){in_m[4]}}, in_m};
        ang_low = ANGLE_BITS'(in_ph * m_ext);
    end

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign k_idx    = k_reg[IDX_W-1:0];
    assign ma_idx   = ma_reg[IDX_W-1:0];

    // Operand select for the shared multiplier
    always_comb begin
        mreq.a          = p1_reg;
        mreq.b          = x_reg;
        mreq.coef_scale = 1'b0;
        case (state_reg)
            S_AS1: begin
                mreq.b = s_reg;
            end
            S_AS2: begin
                mreq.a          = mres;
                mreq.b          = $signed({2'b00, coef_c[k_idx]});
                mreq.coef_scale = 1'b1;
            end
            S_UP2: begin
                mreq.a          = mres;
                mreq.b          = $signed({2'b00, coef_d[ma_idx]});
                mreq.coef_scale = 1'b1;
            end
            S_RC2: begin
                mreq.a          = p0_reg;
                mreq.b          = $signed({2'b00, coef_b[k_idx][ma_idx]});
                mreq.coef_scale = 1'b1;
            end
            S_RC3: begin
                mreq.a          = t1_reg - mres;
                mreq.b          = $signed({2'b00, coef_a[k_idx][ma_idx]});
                mreq.coef_scale = 1'b1;
            end
            S_OUT1: begin
                mreq.b = cd_cos;
            end
            S_OUT2: begin
                mreq.b = cd_sin;
            end
            default: begin
                mreq.a = p1_reg;
            end
        endcase
    end

    assign cd_start = (state_reg == S_TH_START) || (state_reg == S_PH_START);
    assign cd_angle = (state_reg == S_TH_START) ? theta_reg : ang_reg;

    // Sequencer: theta rotation, order recurrence, degree recurrence, then the phase factor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        l_reg     <= in_l;
                        m_reg     <= in_m;
                        ma_reg    <= in_ma;
                        theta_reg <= {in_th, (32-ANGLE_BITS)'(0)};
                        ang_reg   <= {ang_low, (32-ANGLE_BITS)'(0)};
                        p1_reg    <= INV_SQRT_4PI;
                        k_reg     <= K_W'(1);
                        if (in_bad) begin
                            re_reg    <= '0;
                            im_reg    <= '0;
                            flag_reg  <= 1'b1;
                            valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            flag_reg  <= 1'b0;
                            state_reg <= S_TH_START;
                        end
                    end
                end
                S_TH_START: state_reg <= S_TH_WAIT;
                S_TH_WAIT: begin
                    if (cd_done) begin
                        x_reg <= cd_cos;
                        s_reg <= cd_sin[VAL_W-1] ? -cd_sin : cd_sin;
                        if (ma_reg != 5'd0) begin
                            state_reg <= S_AS1;
                        end else if ({1'b0, l_reg} > ma_reg) begin
                            state_reg <= S_UP1;
                        end else begin
                            state_reg <= S_FLIP;
                        end
                    end
                end
                S_AS1: state_reg <= S_AS2;
                S_AS2: state_reg <= S_AS3;
                S_AS3: begin
                    p1_reg <= -mres;
                    k_reg  <= k_reg + 1'b1;
                    if (5'(k_reg) + 5'd1 <= ma_reg) begin
                        state_reg <= S_AS1;
                    end else if ({1'b0, l_reg} > ma_reg) begin
                        state_reg <= S_UP1;
                    end else begin
                        state_reg <= S_FLIP;
                    end
                end
                S_UP1: begin
                    p0_reg    <= p1_reg;
                    state_reg <= S_UP2;
                end
                S_UP2: state_reg <= S_UP3;
                S_UP3: begin
                    p1_reg <= mres;
                    k_reg  <= K_W'(ma_reg + 5'd2);
                    if (ma_reg + 5'd2 <= {1'b0, l_reg}) begin
                        state_reg <= S_RC1;
                    end else begin
                        state_reg <= S_FLIP;
                    end
                end
                S_RC1: state_reg <= S_RC2;
                S_RC2: begin
                    t1_reg    <= mres;
                    state_reg <= S_RC3;
                end
                S_RC3: state_reg <= S_RC4;
                S_RC4: begin
                    p0_reg <= p1_reg;
                    p1_reg <= mres;
                    k_reg  <= k_reg + 1'b1;
                    if (5'(k_reg) + 5'd1 <= {1'b0, l_reg}) begin
                        state_reg <= S_RC1;
                    end else begin
                        state_reg <= S_FLIP;
                    end
                end
                S_FLIP: begin
                    if (m_reg[4] && ma_reg[0]) begin
                        p1_reg <= -p1_reg;
                    end
                    state_reg <= S_PH_START;
                end
                S_PH_START: state_reg <= S_PH_WAIT;
                S_PH_WAIT: begin
                    if (cd_done) begin
                        state_reg <= S_OUT1;
                    end
                end
                S_OUT1: state_reg <= S_OUT2;
                S_OUT2: begin
                    re_reg    <= sat_out(mres);
                    state_reg <= S_OUT3;
                end
                S_OUT3: begin
                    im_reg    <= sat_out(mres);
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    she_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .res  (mres)
    );

    she_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cd_start),
        .angle   (cd_angle),
        .done    (cd_done),
        .cos_out (cd_cos),
        .sin_out (cd_sin)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0000, im_reg, re_reg};
    assign m_axis_tuser  = flag_reg;

    // Input and output sides never open at the same time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    // Accepting a word closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("input still ready after accept");

    // A flagged result carries zero data
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 40'd0))
        else $error("flagged result is not zero");

    // The rotation unit is only started from the busy sequence
    a_cordic_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cd_start |-> (!s_axis_tready && !m_axis_tvalid))
        else $error("rotation started outside a computation");

endmodule

>>> test/spherical_harmonic_eval_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// spherical_harmonic_eval_unit_tb
// Self-checking bench for the complex spherical harmonic unit.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers the extreme degrees and
// orders, the angle extremes and the out-of-range order and degree patterns.
// Random words follow. A bit-accurate predictor computes the CORDIC and the
// Legendre recurrence, and every result word is compared with the oldest
// expected one. The run passes through four idling phases, and in one of them
// the output is held off for a long stretch.
// ============================================================================
module spherical_harmonic_eval_unit_tb;
    import she_pkg::*;

    typedef struct {
        logic signed [17:0] re;
        logic signed [17:0] im;
        logic               oor;
    } harmonic_t;

    typedef struct packed {
        logic [3:0]         l;
        logic [4:0]         m;
        logic [15:0]        theta;
        logic [15:0]        phi;
        logic               typed;
        logic signed [17:0] re;
        logic signed [17:0] im;
        logic               oor;
    } dir_row_t;

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} phase_t;

    localparam int N_DIR       = 22;
    localparam int N_RAND      = 850;
    localparam int HOLD_CYCLES = 400;

    // expectation typed only for zero results: l, m, theta, phi, typed, re, im, oor
    localparam dir_row_t DIR_TABLE [N_DIR] = '{
        '{4'd0,  5'b00000, 16'h0000, 16'h0000, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd0,  5'b00000, 16'hFFFF, 16'hFFFF, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd8,  5'b01000, 16'hFFFF, 16'hFFFF, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd8,  5'b11000, 16'h8000, 16'h4000, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd8,  5'b00000, 16'h4000, 16'h0000, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd8,  5'b00000, 16'h0000, 16'h1234, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd1,  5'b00001, 16'h2000, 16'h2000, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd1,  5'b11111, 16'h2000, 16'h2000, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd3,  5'b11101, 16'hC000, 16'h7FFF, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd5,  5'b00010, 16'h5555, 16'hAAAA, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd7,  5'b11010, 16'h0001, 16'hFFFE, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd2,  5'b00001, 16'h8000, 16'h8000, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd6,  5'b00100, 16'h3FFF, 16'hC001, 1'b0, 18'sd0, 18'sd0, 1'b0},
        '{4'd0,  5'b00001, 16'h1000, 16'h1000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd0,  5'b11111, 16'h1000, 16'h1000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd2,  5'b11101, 16'hFFFF, 16'h0000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd8,  5'b01001, 16'h4000, 16'h4000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd9,  5'b00000, 16'h4000, 16'h4000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd15, 5'b00000, 16'hFFFF, 16'hFFFF, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd15, 5'b01111, 16'h0000, 16'h0000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd4,  5'b10000, 16'h8000, 16'h8000, 1'b1, 18'sd0, 18'sd0, 1'b1},
        '{4'd8,  5'b10111, 16'h2222, 16'h4444, 1'b1, 18'sd0, 18'sd0, 1'b1}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    harmonic_t pending_results [$];
    phase_t    phase = PH_FREE;
    int        hold_left = 0;
    int        n_errors = 0;

    spherical_harmonic_eval_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor
    function automatic longint rnd_q28(longint a, longint b);
        return (a * b + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint rnd_q26(longint v, longint c);
        return (v * c + (64'sd1 <<< 25)) >>> 26;
    endfunction

    // floor(sqrt(num/den)) in Q.26, digit-by-digit root
    function automatic longint sqrt_ratio(longint unsigned num, longint unsigned den);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = (num << 52) / den;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // cosine and sine of a Q0.32 turn, both Q.28
    task automatic turn_cos_sin(input logic [31:0] a, output longint c, output longint s);
        longint x, y, z, nx;
        logic signed [31:0] at;
        x = 652032874;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < 26; i++) begin
            at = turn_atan(i[4:0]);
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - at;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + at;
            end
            x = nx;
        end
        x = (x + 2) >>> 2;
        y = (y + 2) >>> 2;
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic signed [17:0] q16_clip(longint v);
        longint r;
        r = (v + 2048) >>> 12;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    task automatic eval_harmonic(input logic [3:0] l5, input logic [4:0] m5,
                                 input logic [15:0] th, input logic [15:0] ph,
                                 output harmonic_t res);
        longint l, m, ma, x, s, p0, p1, pn, cm, sm, ca, cb;
        logic [31:0] ang;
        l  = l5;
        m  = longint'($signed(m5));
        ma = (m < 0) ? -m : m;
        res.oor = 1'b0;
        if (l > LMAX || ma > l) begin
            res.re = '0;
            res.im = '0;
            res.oor = 1'b1;
            return;
        end
        turn_cos_sin({th, 16'h0}, x, s);
        if (s < 0) s = -s;
        // climb the diagonal to P_|m|^|m|, then up in degree
        p1 = 75724244;
        for (longint k = 1; k <= ma; k++)
            p1 = -rnd_q26(rnd_q28(s, p1), sqrt_ratio(2 * k + 1, 2 * k));
        if (l > ma) begin
            p0 = p1;
            p1 = rnd_q26(rnd_q28(x, p0), sqrt_ratio(2 * ma + 3, 1));
            for (longint k = ma + 2; k <= l; k++) begin
                ca = sqrt_ratio(4 * k * k - 1, k * k - ma * ma);
                cb = sqrt_ratio((k - 1) * (k - 1) - ma * ma, 4 * (k - 1) * (k - 1) - 1);
                pn = rnd_q26(rnd_q28(x, p1) - rnd_q26(p0, cb), ca);
                p0 = p1;
                p1 = pn;
            end
        end
        if (m < 0 && ma[0]) p1 = -p1;
        ang = {ph, 16'h0} * 32'(m);
        turn_cos_sin(ang, cm, sm);
        res.re = q16_clip(rnd_q28(p1, cm));
        res.im = q16_clip(rnd_q28(p1, sm));
    endtask

    // ---------------------------------------------------------------- source
    function automatic bit src_idle();
        case (phase)
            PH_SRC_IDLE: return $urandom_range(99) < 70;
            PH_BOTH:     return $urandom_range(99) < 28;
            default:     return 1'b0;
        endcase
    endfunction

    // offer one word, hold it until taken, then queue its expectation
    task automatic send_word(input logic [3:0] l, input logic [4:0] m,
                             input logic [15:0] th, input logic [15:0] ph,
                             input bit typed, input harmonic_t typed_res);
        harmonic_t res;
        if (src_idle()) begin
            s_axis_tvalid <= 1'b0;
            while (src_idle()) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ph, th, m, l};
        do @(posedge aclk); while (!s_axis_tready);
        if (typed) res = typed_res;
        else eval_harmonic(l, m, th, ph, res);
        pending_results.push_back(res);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(($urandom_range(3)) << 14);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        harmonic_t   tr;
        logic [3:0]  l;
        logic [4:0]  m;
        int          ma;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        foreach (DIR_TABLE[i]) begin
            tr.re = DIR_TABLE[i].re;
            tr.im = DIR_TABLE[i].im;
            tr.oor = DIR_TABLE[i].oor;
            send_word(DIR_TABLE[i].l, DIR_TABLE[i].m, DIR_TABLE[i].theta,
                      DIR_TABLE[i].phi, DIR_TABLE[i].typed, tr);
        end

        // random words, a quarter of them in each idling phase
        for (int n = 0; n < N_RAND; n++) begin
            if (n % (N_RAND / 4) == 0 && n / (N_RAND / 4) < 4) begin
                phase = phase_t'(n / (N_RAND / 4));
                if (phase == PH_SINK_STALL) hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(99) < 85) begin
                l  = 4'($urandom_range(LMAX));
                ma = $urandom_range(int'(l));
                m  = $urandom_range(1) ? 5'(-ma) : 5'(ma);
            end else begin
                l = 4'($urandom);
                m = 5'($urandom);
            end
            send_word(l, m, pick_angle(), pick_angle(), 1'b0, tr);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow the longest latency to pass
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------- sink
    always @(posedge aclk) begin
        harmonic_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if ($signed(m_axis_tdata[17:0]) !== want.re) begin
                    $error("real_part: expected %0d, got %0d", want.re,
                           $signed(m_axis_tdata[17:0]));
                    n_errors++;
                end
                if ($signed(m_axis_tdata[35:18]) !== want.im) begin
                    $error("imag_part: expected %0d, got %0d", want.im,
                           $signed(m_axis_tdata[35:18]));
                    n_errors++;
                end
                if (m_axis_tuser !== want.oor) begin
                    $error("order_out_of_range: expected %0b, got %0b", want.oor,
                           m_axis_tuser);
                    n_errors++;
                end
            end
        end
        // hold off for the long stretch, else stall by phase
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (phase)
                PH_SINK_STALL: m_axis_tready <= $urandom_range(99) >= 70;
                PH_BOTH:       m_axis_tready <= $urandom_range(99) >= 28;
                default:       m_axis_tready <= 1'b1;
            endcase
        end
    end

    // ---------------------------------------------------------------- timeout
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
